FILE: src/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame decoder: transfer
// payloads, front-to-back command record, status and command codes.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    // reset value of the frame size limit
    localparam logic [31:0] MAX_FRAME_RESET = 32'd2048;
    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // result status codes
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_HDR_ERR  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // command kinds handed from front to back
    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_DONE = 2'd1;
    localparam logic [1:0] CMD_ERR  = 2'd2;

    // input transfer
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_item;

    // result transfer
    typedef struct packed {
        logic [2:0]  status;
        logic        has_data;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic        frame_last;
        logic [31:0] payload_length;
        logic [3:0]  header_length;
        logic [31:0] bytes_missing;
    } t_out_item;

    // one classified byte that produces a result
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic [7:0]  key_byte;
        logic        buf_end;
        logic        data_last;
        logic        too_long;
        logic [3:0]  opcode;
        logic [31:0] plen;
        logic [3:0]  hlen;
        logic [31:0] missing;
    } t_cmd;

endpackage

FILE: src/wsfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: takes one byte per cycle while the queue is not full,
// tracks the frame phase, counts header and payload bytes, and pushes a
// command for every byte that causes a result.
// ----------------------------------------------------------------------------
module wsfd_front
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    input  logic [31:0] i_max_frame_bytes,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DROP    = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic [3:0]  r_htot, n_htot;
    logic [3:0]  r_op, n_op;
    logic        r_masked, n_masked;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_idx, n_idx;

    logic        w_fire;
    logic        w_push;
    logic        w_done_req;
    logic        w_err_req;
    logic        w_too_long;
    logic [3:0]  w_ext_end;
    logic [6:0]  w_code;
    logic [7:0]  w_key_byte;
    logic [32:0] w_total;
    t_cmd        w_cmd;

    assign o_ready = !i_full;
    assign w_fire  = i_valid && !i_full;
    assign w_code  = i_item.rx_byte[6:0];

    // end of the extended length field
    assign w_ext_end = r_htot - (r_masked ? 4'd4 : 4'd0);

    // rotating mask key byte
    always_comb begin
        case (r_idx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
        if (!r_masked) begin
            w_key_byte = 8'd0;
        end
    end

    // phase machine and command build
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_htot     = r_htot;
        n_op       = r_op;
        n_masked   = r_masked;
        n_len      = r_len;
        n_rem      = r_rem;
        n_key      = r_key;
        n_idx      = r_idx;
        w_push     = 1'b0;
        w_done_req = 1'b0;
        w_err_req  = 1'b0;
        w_cmd      = '0;

        unique case (r_phase)
            PH_LEN: begin
                n_masked = i_item.rx_byte[7];
                n_count  = 4'd2;
                n_htot   = 4'd2 + (w_code == 7'd126 ? 4'd2 : (w_code == 7'd127 ? 4'd8 : 4'd0))
                           + (i_item.rx_byte[7] ? 4'd4 : 4'd0);
                n_len    = (w_code < 7'd126) ? {25'd0, w_code} : 32'd0;
                n_key    = 32'd0;
                if (n_htot == 4'd2) begin
                    w_done_req = 1'b1;
                end else if (i_item.buffer_end) begin
                    w_err_req = 1'b1;
                end else begin
                    n_phase = (w_code >= 7'd126) ? PH_EXT : PH_MASK;
                end
            end
            PH_EXT: begin
                if (w_ext_end == 4'd10 && r_count < 4'd6 && i_item.rx_byte != 8'd0) begin
                    w_err_req = 1'b1;
                end else begin
                    n_len   = {r_len[23:0], i_item.rx_byte};
                    n_count = r_count + 4'd1;
                    if (n_count == r_htot) begin
                        w_done_req = 1'b1;
                    end else if (i_item.buffer_end) begin
                        w_err_req = 1'b1;
                    end else if (n_count == w_ext_end) begin
                        n_phase = PH_MASK;
                    end
                end
            end
            PH_MASK: begin
                n_key   = {r_key[23:0], i_item.rx_byte};
                n_count = r_count + 4'd1;
                if (n_count == r_htot) begin
                    w_done_req = 1'b1;
                end else if (i_item.buffer_end) begin
                    w_err_req = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_idx           = r_idx + 2'd1;
                n_rem           = r_rem - 32'd1;
                w_push          = 1'b1;
                w_cmd.kind      = CMD_DATA;
                w_cmd.rx_byte   = i_item.rx_byte;
                w_cmd.key_byte  = w_key_byte;
                w_cmd.buf_end   = i_item.buffer_end;
                w_cmd.data_last = (n_rem == 32'd0);
                w_cmd.opcode    = r_op;
                w_cmd.plen      = r_len;
                w_cmd.hlen      = r_htot;
                w_cmd.missing   = n_rem;
                if (n_rem == 32'd0) begin
                    n_phase = i_item.buffer_end ? PH_IDLE : PH_DROP;
                end else if (i_item.buffer_end) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DROP: begin
                if (i_item.buffer_end) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // first header byte: FIN and opcode check
                if (!i_item.rx_byte[7] ||
                    !(i_item.rx_byte[3:0] <= 4'd2 || i_item.rx_byte[3:0] == 4'd8 ||
                      i_item.rx_byte[3:0] == 4'd9 || i_item.rx_byte[3:0] == 4'd10)) begin
                    w_err_req = 1'b1;
                end else begin
                    n_op     = i_item.rx_byte[3:0];
                    n_count  = 4'd1;
                    n_htot   = 4'd0;
                    n_masked = 1'b0;
                    n_len    = 32'd0;
                    n_rem    = 32'd0;
                    n_key    = 32'd0;
                    n_idx    = 2'd0;
                    if (i_item.buffer_end) begin
                        w_err_req = 1'b1;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
        endcase

        // header length plus payload length against the limit, no overflow
        w_total    = {1'b0, n_len} + {29'd0, n_htot};
        w_too_long = w_total > {1'b0, i_max_frame_bytes};

        // header complete: result now, or start of payload
        if (w_done_req) begin
            if (w_too_long || n_len == 32'd0 || i_item.buffer_end) begin
                w_push         = 1'b1;
                w_cmd.kind     = CMD_DONE;
                w_cmd.buf_end  = i_item.buffer_end;
                w_cmd.too_long = w_too_long;
                w_cmd.opcode   = r_op;
                w_cmd.plen     = n_len;
                w_cmd.hlen     = n_htot;
                n_phase        = i_item.buffer_end ? PH_IDLE : PH_DROP;
            end else begin
                n_rem   = n_len;
                n_idx   = 2'd0;
                n_phase = PH_PAYLOAD;
            end
        end

        // header error: drop the rest of the buffer
        if (w_err_req) begin
            w_push     = 1'b1;
            w_cmd      = '0;
            w_cmd.kind = CMD_ERR;
            n_phase    = i_item.buffer_end ? PH_IDLE : PH_DROP;
        end
    end

    assign o_push = w_fire && w_push;
    assign o_cmd  = w_cmd;

    // state registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= 4'd0;
            r_htot   <= 4'd0;
            r_op     <= 4'd0;
            r_masked <= 1'b0;
            r_len    <= 32'd0;
            r_rem    <= 32'd0;
            r_key    <= 32'd0;
            r_idx    <= 2'd0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_htot   <= n_htot;
            r_op     <= n_op;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

endmodule

FILE: src/wsfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_queue
// Small command FIFO between parser and result stage; lets each side
// stall on its own.
// ----------------------------------------------------------------------------
module wsfd_queue
    import wsfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_pop && o_not_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/wsfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_back
// Result stage: turns a command into a result (status, unmasking, frame
// end flag) and holds it in the output register until transferred.
// ----------------------------------------------------------------------------
module wsfd_back
    import wsfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    assign o_pop   = i_cmd_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // result formatting
    always_comb begin
        n_item = '0;
        unique case (i_cmd.kind)
            CMD_DATA: begin
                n_item.has_data       = 1'b1;
                n_item.payload_byte   = i_cmd.rx_byte ^ i_cmd.key_byte;
                n_item.frame_opcode   = i_cmd.opcode;
                n_item.payload_length = i_cmd.plen;
                n_item.header_length  = i_cmd.hlen;
                if (i_cmd.data_last) begin
                    n_item.status     = ST_DATA;
                    n_item.frame_last = 1'b1;
                end else if (i_cmd.buf_end) begin
                    n_item.status        = ST_TRUNC;
                    n_item.frame_last    = 1'b1;
                    n_item.bytes_missing = i_cmd.missing;
                end else begin
                    n_item.status = ST_DATA;
                end
            end
            CMD_DONE: begin
                n_item.frame_opcode   = i_cmd.opcode;
                n_item.frame_last     = 1'b1;
                n_item.payload_length = i_cmd.plen;
                n_item.header_length  = i_cmd.hlen;
                if (i_cmd.too_long) begin
                    n_item.status = ST_TOO_LONG;
                end else if (i_cmd.plen == 32'd0) begin
                    n_item.status = ST_EMPTY;
                end else begin
                    n_item.status        = ST_TRUNC;
                    n_item.bytes_missing = i_cmd.plen;
                end
            end
            default: begin
                n_item.status     = ST_HDR_ERR;
                n_item.frame_last = 1'b1;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: src/websocket_frame_decoder.sv
`timescale 1ns / 1ps
// A byte that causes a result is written into the command queue, then into the output register.
// Throughput: one byte per cycle while the command queue is not full.
// Header bytes that cause no result leave the queue untouched.
// Reset (synchronous, active low): parser idle, queue and output register empty,
// frame size limit back to 2048 bytes.
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Byte-serial WebSocket frame header parser and payload unmasker: parser
// front, command queue, result stage.
// ----------------------------------------------------------------------------
module websocket_frame_decoder
    import wsfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0] r_max_frame_bytes;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_not_empty;
    t_cmd        w_push_cmd;
    t_cmd        w_head_cmd;

    // frame size limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= MAX_FRAME_RESET;
        end else if (i_cfg_we) begin
            r_max_frame_bytes <= i_cfg_wdata;
        end
    end

    wsfd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_item            (i_in_item),
        .i_max_frame_bytes (r_max_frame_bytes),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_cmd             (w_push_cmd)
    );

    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_push_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_head_cmd)
    );

    wsfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_not_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

endmodule
